/* rtl/spl_pkg.sv */
// Package for the sorted priority list.
// Holds the command and result structs, operation and status codes, FSM states
// and default sizes. No dependencies.
package spl_pkg;

  localparam int unsigned CapacityDef     = 16;
  localparam int unsigned ValueBitsDef    = 32;
  localparam int unsigned PriorityBitsDef = 16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DUMP   = 1'b1
  } spl_func_e;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_DUMP_ENTRY = 2'd2,
    ST_DUMP_EMPTY = 2'd3
  } spl_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_HEAD,
    S_DUMP
  } spl_state_e;

  typedef struct packed {
    spl_func_e          func;
    logic [31:0]        item_value;
    logic signed [15:0] item_priority;
  } spl_in_t;

  typedef struct packed {
    logic [31:0]        out_value;
    logic signed [15:0] out_priority;
    logic               last;
    spl_status_e        status;
    logic [6:0]         fill_count;
  } spl_out_t;

endpackage

/* rtl/sorted_priority_list.sv */
// Sorted priority list, top level.
// Entry memory, insert/dump sequencer and result register; uses spl_pkg.
//
// Usage:
//   A command transfer takes place at a rising edge with start high and busy
//   low. func selects insert (value with signed priority) or dump.
//   Each result sits on result_o for exactly one cycle with result_valid_o
//   high; there is no back pressure.
// Insert: the entries live in one memory, kept in ascending priority order.
//   The new entry is placed after all entries of equal or lower priority, so
//   equal priorities stay first in, first out. The sequencer walks from the
//   tail down, one read-compare-write per cycle, moving each higher entry up
//   by one slot. Into an empty or full list the result is registered from
//   S_IDLE; otherwise it is registered with the write of the new entry, in
//   S_INSERT or S_HEAD. A full list drops the entry and reports it.
// Dump: one result per stored entry, one per cycle, read in S_DUMP; the
//   final one carries last. An empty list gives one status.
// busy stays high until the last result of the command is issued, so the
//   next command can be taken in the cycle that result is shown.
// Reset clears the fill count and the sequencer; memory contents are left.
module sorted_priority_list
  import spl_pkg::*;
#(
  parameter int unsigned CAPACITY      = CapacityDef,
  parameter int unsigned VALUE_BITS    = ValueBitsDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spl_in_t  cmd_i,
  output logic     result_valid_o,
  output spl_out_t result_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = VALUE_BITS + PRIORITY_BITS;

  logic [ENT_W-1:0] mem [CAPACITY];
  logic [ENT_W-1:0] rdata_q;
  logic [ENT_W-1:0] wdata;
  logic [AW-1:0]    raddr, waddr;
  logic             we;

  spl_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [ENT_W-1:0] ent_q, ent_d;
  logic             res_valid_q, res_valid_d;
  spl_out_t         res_q, res_d;

  logic [VALUE_BITS-1:0]    new_value, rd_value;
  logic [PRIORITY_BITS-1:0] new_prio, rd_prio, ent_prio;
  logic [ENT_W-1:0]         new_word;
  logic                     rd_above;
  logic                     dump_last;

  assign new_value = VALUE_BITS'(cmd_i.item_value);
  assign new_prio  = PRIORITY_BITS'(cmd_i.item_priority);
  assign new_word  = {new_prio, new_value};
  assign rd_value  = rdata_q[VALUE_BITS-1:0];
  assign rd_prio   = rdata_q[ENT_W-1:VALUE_BITS];
  assign ent_prio  = ent_q[ENT_W-1:VALUE_BITS];
  assign rd_above  = $signed(rd_prio) > $signed(ent_prio);
  assign dump_last = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    ent_d       = ent_q;
    we          = 1'b0;
    waddr       = ptr_q + AW'(1);
    wdata       = rdata_q;
    raddr       = ptr_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    res_d.status = ST_INSERTED;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (cmd_i.func == FUNC_INSERT) begin
            priority if (count_q == CNT_W'(CAPACITY)) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_FULL;
            end else if (count_q == '0) begin
              we          = 1'b1;
              waddr       = '0;
              wdata       = new_word;
              count_d     = count_q + CNT_W'(1);
              res_valid_d = 1'b1;
            end else begin
              ent_d   = new_word;
              raddr   = AW'(count_q - CNT_W'(1));
              ptr_d   = AW'(count_q - CNT_W'(1));
              state_d = S_INSERT;
            end
          end else begin
            if (count_q == '0) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_DUMP_EMPTY;
            end else begin
              raddr   = '0;
              ptr_d   = '0;
              state_d = S_DUMP;
            end
          end
        end
      end
      S_INSERT: begin
        we = 1'b1;
        if (rd_above) begin
          wdata = rdata_q;
          if (ptr_q == '0) begin
            state_d = S_HEAD;
          end else begin
            ptr_d = ptr_q - AW'(1);
            raddr = ptr_q - AW'(1);
          end
        end else begin
          wdata       = ent_q;
          count_d     = count_q + CNT_W'(1);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_HEAD: begin
        we          = 1'b1;
        waddr       = '0;
        wdata       = ent_q;
        count_d     = count_q + CNT_W'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DUMP: begin
        res_valid_d        = 1'b1;
        res_d.status       = ST_DUMP_ENTRY;
        res_d.out_value    = 32'(rd_value);
        res_d.out_priority = 16'(rd_prio);
        res_d.last         = dump_last;
        if (dump_last) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + AW'(1);
          raddr = ptr_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.fill_count = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    res_q <= res_d;
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* tb/sv/priority_list_scoreboard_pkg.sv */
// Scoreboard for the sorted priority list testbench.
// Keeps its own ordered copy of the stored entries and checks each result.
// Depends on spl_pkg.
`timescale 1ns / 100ps

package priority_list_scoreboard_pkg;
  import spl_pkg::*;

  class priority_list_scoreboard;
    logic [31:0]        list_values[CapacityDef];
    logic signed [15:0] list_prios[CapacityDef];
    int                 list_count;
    spl_out_t           pending_results[$];
    int unsigned        mismatches;

    function new();
      list_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add_expected(spl_out_t r);
      pending_results = {pending_results, r};
    endfunction

    // Works out the results of one accepted command and updates the list copy.
    function void note_command(spl_in_t c);
      spl_out_t r;
      int       pos;
      r = '0;
      r.last = 1'b1;
      if (c.func == FUNC_INSERT) begin
        if (list_count >= int'(CapacityDef)) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < list_count && list_prios[pos] <= $signed(c.item_priority)) pos++;
          for (int i = list_count; i > pos; i--) begin
            list_values[i] = list_values[i-1];
            list_prios[i]  = list_prios[i-1];
          end
          list_values[pos] = c.item_value;
          list_prios[pos]  = c.item_priority;
          list_count++;
          r.status = ST_INSERTED;
        end
        r.fill_count = 7'(list_count);
        add_expected(r);
      end else if (list_count == 0) begin
        r.status = ST_DUMP_EMPTY;
        add_expected(r);
      end else begin
        for (int i = 0; i < list_count; i++) begin
          r.out_value    = list_values[i];
          r.out_priority = list_prios[i];
          r.last         = (i + 1 == list_count);
          r.status       = ST_DUMP_ENTRY;
          r.fill_count   = 7'(list_count);
          add_expected(r);
        end
      end
    endfunction

    function void check_result(spl_out_t got);
      spl_out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: value %h prio %0d last %b status %0d fill %0d",
                   $time, got.out_value, got.out_priority, got.last, got.status,
                   got.fill_count);
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.out_value !== want.out_value || got.out_priority !== want.out_priority ||
          got.last !== want.last || got.status !== want.status ||
          got.fill_count !== want.fill_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected: value %h prio %0d last %b status %0d fill %0d",
                   want.out_value, want.out_priority, want.last, want.status,
                   want.fill_count);
          $display("  actual:   value %h prio %0d last %b status %0d fill %0d",
                   got.out_value, got.out_priority, got.last, got.status,
                   got.fill_count);
        end
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb.sv */
// Top-level testbench for sorted_priority_list.
// Drives directed commands, then insert and dump commands in random bursts,
// and checks every result transfer; depends on spl_pkg and priority_list_scoreboard_pkg.
`timescale 1ns / 100ps

module tb;
  import spl_pkg::*;
  import priority_list_scoreboard_pkg::*;

  localparam int NumRandomCmds = 380;
  localparam int StallLimit    = 500;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  spl_in_t  cmd;
  logic     result_valid_o;
  spl_out_t result;

  priority_list_scoreboard ledger;
  int                      stall_cycles = 0;

  sorted_priority_list DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (result_valid_o),
    .result_o       (result)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results are checked before the command of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (result_valid_o === 1'b1) ledger.check_result(result);
      if (start === 1'b1 && busy === 1'b0) ledger.note_command(cmd);
      if (result_valid_o === 1'b1 || (start === 1'b1 && busy === 1'b0)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_command(input spl_func_e f, input logic [31:0] v,
                              input logic signed [15:0] p);
    spl_in_t c;
    c.func          = f;
    c.item_value    = v;
    c.item_priority = p;
    @(negedge clk_i);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    spl_func_e          f;
    logic [31:0]        v;
    logic signed [15:0] p;
    int                 burst_left;

    ledger = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty dump, extremes, equal priorities at head, middle and tail
    send_command(FUNC_DUMP,   32'h0000_0000, 16'sd0);
    send_command(FUNC_INSERT, 32'h0000_0000, 16'sd0);
    send_command(FUNC_DUMP,   32'hFFFF_FFFF, -16'sd1);
    send_command(FUNC_INSERT, 32'hFFFF_FFFF, -16'sd32768);
    send_command(FUNC_INSERT, 32'h0000_0001, 16'sd32767);
    send_command(FUNC_INSERT, 32'h0000_0002, 16'sd0);
    send_command(FUNC_INSERT, 32'h0000_0003, -16'sd32768);
    send_command(FUNC_INSERT, 32'h0000_0004, 16'sd32767);
    send_command(FUNC_INSERT, 32'hA5A5_5A5A, -16'sd1);
    send_command(FUNC_DUMP,   32'h0000_0000, 16'sd0);
    wait_drained();

    // random: list fills up, then full drops and full dumps
    burst_left = 0;
    for (int n = 0; n < NumRandomCmds; n++) begin
      if (n == NumRandomCmds / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      end
      burst_left--;
      f = ($urandom_range(0, 9) < 3) ? FUNC_DUMP : FUNC_INSERT;
      v = $urandom;
      case ($urandom_range(0, 3))
        0: p = 16'($urandom_range(0, 8) - 4);
        1: p = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: p = 16'($urandom);
      endcase
      send_command(f, v, p);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/spl_pkg.sv
rtl/sorted_priority_list.sv
tb/sv/priority_list_scoreboard_pkg.sv
tb/sv/tb.sv
